@@ rtl/pdf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdf_pkg - shared definitions for the polyphase decimating FIR
// Widths, the Q1.16 coefficient table and the control structs passed
// between the pipeline stages.
// ----------------------------------------------------------------------------
package pdf_pkg;

    localparam int PHASES     = 4;
    localparam int TAPS       = 11;
    localparam int PHASE_W    = $clog2(PHASES);
    localparam int DATA_W     = 32;
    localparam int COEF_W     = 17;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = DATA_W + COEF_W;
    localparam int GROUP_SIZE = 4;
    localparam int GROUPS     = (TAPS + GROUP_SIZE - 1) / GROUP_SIZE;

    typedef logic signed [DATA_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic [TAPS-1:0][DATA_W-1:0] tap_row_t;
    typedef logic [GROUPS-1:0][DATA_W-1:0] group_sums_t;

    // Rows are indexed by branch number.
    localparam coef_t COEF_TAB [PHASES][TAPS] = '{
        '{-17'sd1, -17'sd2, -17'sd1, 17'sd1, -17'sd1, 17'sd32770,
          -17'sd1, 17'sd1, -17'sd1, -17'sd2, -17'sd1},
        '{-17'sd3402, -17'sd1198, -17'sd1749, -17'sd2883, -17'sd6910, 17'sd20849,
          17'sd4100, 17'sd2194, 17'sd1432, 17'sd1015, 17'sd0},
        '{-17'sd1, 17'sd0, -17'sd2, 17'sd0, 17'sd0, 17'sd0,
          17'sd0, -17'sd2, 17'sd0, -17'sd1, 17'sd0},
        '{17'sd1015, 17'sd1432, 17'sd2194, 17'sd4100, 17'sd20849, -17'sd6910,
          -17'sd2883, -17'sd1749, -17'sd1198, -17'sd3402, 17'sd0}
    };

    typedef struct packed {
        logic               valid;
        logic               last;
        logic [PHASE_W-1:0] br;
    } stage_ctrl_t;

    typedef struct packed {
        logic valid;
        logic last;
    } sum_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/pdf_stream_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdf_stream_ifs - valid/ready channels of the polyphase decimating FIR
// One interface for the input samples, one for the filtered results.
// ----------------------------------------------------------------------------
interface pdf_sample_if;
    logic             valid;
    logic             ready;
    pdf_pkg::sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface pdf_result_if;
    logic             valid;
    logic             ready;
    pdf_pkg::sample_t filtered_sample;

    modport source (output valid, output filtered_sample, input ready);
    modport sink   (input valid, input filtered_sample, output ready);
endinterface

`default_nettype wire

@@ rtl/pdf_dot.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdf_dot - branch dot product, two pipeline stages
// Stage B multiplies each tap by its coefficient and floors to Q16.16;
// stage C reduces the products to three group sums.
// ----------------------------------------------------------------------------
module pdf_dot (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire pdf_pkg::stage_ctrl_t up_ctrl,
    input  wire pdf_pkg::tap_row_t    up_taps,
    output logic                      up_ready,
    output pdf_pkg::sum_ctrl_t        dn_ctrl,
    output pdf_pkg::group_sums_t      dn_sums,
    input  wire                       dn_ready
);

    logic                b_valid_reg, b_valid_next;
    logic                b_last_reg;
    pdf_pkg::tap_row_t   prod_reg;
    pdf_pkg::tap_row_t   prod_next;
    logic                c_valid_reg, c_valid_next;
    logic                c_last_reg;
    pdf_pkg::group_sums_t grp_reg;
    pdf_pkg::group_sums_t grp_next;
    logic                b_ready;
    logic                c_ready;
    logic                b_load;
    logic                c_load;

    assign c_ready  = !c_valid_reg || dn_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign up_ready = b_ready;
    assign b_load   = up_ctrl.valid && b_ready;
    assign c_load   = b_valid_reg && c_ready;

    // Floor each Q17.32 product to Q16.16 and keep the low word.
    always_comb
    begin
        logic signed [pdf_pkg::PROD_W-1:0] prod;
        prod_next = '0;
        for (int t = 0; t < pdf_pkg::TAPS; t++)
        begin
            prod = pdf_pkg::PROD_W'($signed(up_taps[t]))
                   * pdf_pkg::PROD_W'(pdf_pkg::COEF_TAB[up_ctrl.br][t]);
            prod_next[t] = prod[pdf_pkg::FRAC_W +: pdf_pkg::DATA_W];
        end
    end

    always_comb
    begin
        int idx;
        grp_next = '0;
        for (int g = 0; g < pdf_pkg::GROUPS; g++)
        begin
            for (int k = 0; k < pdf_pkg::GROUP_SIZE; k++)
            begin
                idx = g * pdf_pkg::GROUP_SIZE + k;
                if (idx < pdf_pkg::TAPS)
                begin
                    grp_next[g] = grp_next[g] + prod_reg[idx];
                end
            end
        end
    end

    always_comb
    begin
        b_valid_next = b_load ? 1'b1 : (c_load ? 1'b0 : b_valid_reg);
        c_valid_next = c_load ? 1'b1 : (dn_ready ? 1'b0 : c_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            prod_reg   <= prod_next;
            b_last_reg <= up_ctrl.last;
        end
        if (c_load)
        begin
            grp_reg    <= grp_next;
            c_last_reg <= b_last_reg;
        end
    end

    assign dn_ctrl.valid = c_valid_reg;
    assign dn_ctrl.last  = c_last_reg;
    assign dn_sums       = grp_reg;

endmodule

`default_nettype wire

@@ rtl/polyphase_decimating_fir.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polyphase_decimating_fir - decimate-by-4 polyphase low-pass FIR, Q16.16
// Four branches of eleven taps; one filtered sample per four input samples.
// ----------------------------------------------------------------------------
// Usage:
//   sample_ch carries signed Q16.16 input samples, result_ch carries the
//   decimated output. A transaction takes place on a rising edge with valid
//   and ready both high.
//   Every fourth accepted sample closes an output: its result passes
//   through stages A to C into the output register that drives result_ch.
//   Unless the pipe backs up, the four-stage pipeline takes one sample per
//   cycle: tap update, eleven parallel multipliers, group adders, accumulator.
//   When the receiver stalls, the pending result holds in the output
//   register; samples that produce no output keep flowing, and the pipe
//   backs up only when a closing sample reaches the accumulator while the
//   output register is still full. Ready then drops once every stage is full.
//   Reset clears the delay lines, the phase counter and the accumulator;
//   the block accepts samples in the first cycle after reset.
// ----------------------------------------------------------------------------
module polyphase_decimating_fir (
    input  wire          clk,
    input  wire          rst_n,
    pdf_sample_if.sink   sample_ch,
    pdf_result_if.source result_ch
);

    // Branch delay lines held in rotating order: row 0 is always the branch
    // the next sample goes to (branch 3 first, then 2, 1, 0).
    logic [pdf_pkg::PHASES-1:0][pdf_pkg::TAPS-1:0][pdf_pkg::DATA_W-1:0] rows_reg, rows_next;
    logic [pdf_pkg::PHASE_W-1:0] phase_reg, phase_next;

    pdf_pkg::tap_row_t    new_row;
    pdf_pkg::tap_row_t    taps_a_reg;
    pdf_pkg::stage_ctrl_t ctrl_a_reg, ctrl_a_next;
    logic                 a_ready;
    logic                 a_take;
    logic                 dot_ready;

    pdf_pkg::sum_ctrl_t   sum_ctrl;
    pdf_pkg::group_sums_t sums;
    logic                 d_ready;
    logic                 d_take;

    logic [pdf_pkg::DATA_W-1:0] acc_reg, acc_next;
    logic [pdf_pkg::DATA_W-1:0] part;
    logic [pdf_pkg::DATA_W-1:0] total;
    logic                       out_valid_reg, out_valid_next;
    logic [pdf_pkg::DATA_W-1:0] out_data_reg;

    // ---------------- stage A: tap update on acceptance ----------------
    assign a_ready         = !ctrl_a_reg.valid || dot_ready;
    assign sample_ch.ready = a_ready;
    assign a_take          = sample_ch.valid && a_ready;

    // Shift the sample into the current branch, oldest tap drops out.
    always_comb
    begin
        new_row[0] = sample_ch.sample;
        for (int t = 1; t < pdf_pkg::TAPS; t++)
        begin
            new_row[t] = rows_reg[0][t-1];
        end
    end

    always_comb
    begin
        rows_next  = rows_reg;
        phase_next = phase_reg;
        if (a_take)
        begin
            for (int r = 0; r < pdf_pkg::PHASES - 1; r++)
            begin
                rows_next[r] = rows_reg[r+1];
            end
            rows_next[pdf_pkg::PHASES-1] = new_row;
            phase_next = (phase_reg == pdf_pkg::PHASE_W'(pdf_pkg::PHASES - 1))
                         ? '0 : phase_reg + 1'b1;
        end
    end

    always_comb
    begin
        ctrl_a_next = ctrl_a_reg;
        if (a_take)
        begin
            ctrl_a_next.valid = 1'b1;
            ctrl_a_next.last  = (phase_reg == pdf_pkg::PHASE_W'(pdf_pkg::PHASES - 1));
            ctrl_a_next.br    = pdf_pkg::PHASE_W'(pdf_pkg::PHASES - 1) - phase_reg;
        end
        else if (dot_ready)
        begin
            ctrl_a_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= '0;
            phase_reg  <= '0;
            ctrl_a_reg <= '0;
        end
        else
        begin
            rows_reg   <= rows_next;
            phase_reg  <= phase_next;
            ctrl_a_reg <= ctrl_a_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_take)
        begin
            taps_a_reg <= new_row;
        end
    end

    // ---------------- stages B and C: products and group sums ----------------
    pdf_dot u_dot (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_ctrl  (ctrl_a_reg),
        .up_taps  (taps_a_reg),
        .up_ready (dot_ready),
        .dn_ctrl  (sum_ctrl),
        .dn_sums  (sums),
        .dn_ready (d_ready)
    );

    // ---------------- stage D: accumulate and emit ----------------
    // A non-closing sample only updates the accumulator, so it never waits;
    // a closing one needs the output register free.
    assign d_ready = !sum_ctrl.last || !out_valid_reg || result_ch.ready;
    assign d_take  = sum_ctrl.valid && d_ready;

    always_comb
    begin
        part = '0;
        for (int g = 0; g < pdf_pkg::GROUPS; g++)
        begin
            part = part + sums[g];
        end
        total = acc_reg + part;
    end

    always_comb
    begin
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !result_ch.ready;
        if (d_take)
        begin
            if (sum_ctrl.last)
            begin
                acc_next       = '0;
                out_valid_next = 1'b1;
            end
            else
            begin
                acc_next = total;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_take && sum_ctrl.last)
        begin
            out_data_reg <= total;
        end
    end

    assign result_ch.valid           = out_valid_reg;
    assign result_ch.filtered_sample = out_data_reg;

endmodule

`default_nettype wire
